// ===== rtl/pcss_pkg.sv =====
`timescale 1ns / 1ps

package pcss_pkg;

    localparam int POS_BITS  = 32;
    localparam int VAL_BITS  = 32;
    localparam int MASK_BITS = 26;
    localparam int RES_BITS  = 5;
    localparam int NSLOT     = 4;
    localparam int QPTR      = 3;
    localparam int QDEPTH    = 1 << QPTR;

    typedef enum logic [1:0] {
        ACT_RESIDUE = 2'd0,
        ACT_FINISH  = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_N_CLEAVE  = 2'd0,
        CFG_N_EXCEPT  = 2'd1,
        CFG_C_CLEAVE  = 2'd2,
        CFG_C_EXCEPT  = 2'd3
    } t_cfg_index;

    localparam logic KIND_SITE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [MASK_BITS-1:0] RST_N_CLEAVE = 26'h0000000;
    localparam logic [MASK_BITS-1:0] RST_N_EXCEPT = 26'h0000000;
    localparam logic [MASK_BITS-1:0] RST_C_CLEAVE = 26'h0020400;  // K, R
    localparam logic [MASK_BITS-1:0] RST_C_EXCEPT = 26'h0008000;  // P

    typedef struct packed {
        logic                kind;
        logic [VAL_BITS-1:0] value;
        logic                final_res;
    } t_result;

    typedef struct packed {
        logic [NSLOT-1:0]    en;
        t_result [NSLOT-1:0] res;
    } t_batch;

    // letters above Z match nothing
    function automatic logic letter_in(input logic [MASK_BITS-1:0] mask,
                                       input logic [RES_BITS-1:0] letter);
        logic [(1 << RES_BITS)-1:0] wide;
        wide = {{((1 << RES_BITS) - MASK_BITS){1'b0}}, mask};
        return wide[letter];
    endfunction

    // low bits of a position, zero-extended when the position is narrower
    function automatic logic [VAL_BITS-1:0] pos_value(input logic [POS_BITS-1:0] p);
        logic [POS_BITS+VAL_BITS-1:0] wide;
        wide = {{VAL_BITS{1'b0}}, p};
        return wide[VAL_BITS-1:0];
    endfunction

endpackage

// ===== rtl/pcss_eval.sv =====
`timescale 1ns / 1ps

module pcss_eval import pcss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [MASK_BITS-1:0] i_cfg_data,
    input  logic                 i_fire,
    input  logic [1:0]           i_action,
    input  logic [RES_BITS-1:0]  i_residue,
    input  logic                 i_first,
    input  logic                 i_last,
    output t_batch               o_batch
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [MASK_BITS-1:0] r_n_cleave, r_n_except, r_c_cleave, r_c_except;

    logic [POS_BITS-1:0]  r_position;
    logic [RES_BITS-1:0]  r_prev;
    logic                 r_pending;
    logic [POS_BITS-1:0]  r_last_site;
    logic                 r_have_site;
    logic [VAL_BITS-1:0]  r_count;
    logic                 r_finished;

    logic [POS_BITS-1:0]  pos_inc;
    logic                 do_res;
    logic                 emit_a, emit_b, emit_c;
    logic                 have1;
    logic [POS_BITS-1:0]  last1;
    logic [1:0]           n_sites;
    logic [VAL_BITS+1:0]  cnt_sum;
    logic [VAL_BITS-1:0]  n_count;
    logic [POS_BITS-1:0]  n_last_site;

    always_comb begin
        pos_inc = (r_position == POS_MAX) ? r_position : r_position + 1'b1;
        do_res  = i_fire && (t_action'(i_action) == ACT_RESIDUE) && !r_finished;

        emit_a = r_pending && (i_first || !letter_in(r_c_except, i_residue));
        have1  = r_have_site || emit_a;
        last1  = emit_a ? r_position : r_last_site;
        emit_b = letter_in(r_n_cleave, i_residue)
                 && (i_first || !letter_in(r_n_except, r_prev))
                 && !(have1 && (last1 == r_position));
        emit_c = letter_in(r_c_cleave, i_residue) && i_last;

        n_sites = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
        cnt_sum = {2'b00, r_count} + {{VAL_BITS{1'b0}}, n_sites};
        n_count = (cnt_sum[VAL_BITS+1:VAL_BITS] != 2'b00) ? '1 : cnt_sum[VAL_BITS-1:0];

        if (emit_c) begin
            n_last_site = pos_inc;
        end else if (emit_a || emit_b) begin
            n_last_site = r_position;
        end else begin
            n_last_site = r_last_site;
        end

        o_batch.en[0] = do_res && emit_a;
        o_batch.en[1] = do_res && emit_b;
        o_batch.en[2] = do_res && emit_c;
        o_batch.en[3] = do_res && i_last;

        o_batch.res[0].kind      = KIND_SITE;
        o_batch.res[0].value     = pos_value(r_position);
        o_batch.res[0].final_res = !emit_b && !emit_c && !i_last;
        o_batch.res[1].kind      = KIND_SITE;
        o_batch.res[1].value     = pos_value(r_position);
        o_batch.res[1].final_res = !emit_c && !i_last;
        o_batch.res[2].kind      = KIND_SITE;
        o_batch.res[2].value     = pos_value(pos_inc);
        o_batch.res[2].final_res = !i_last;
        o_batch.res[3].kind      = KIND_END;
        o_batch.res[3].value     = n_count;
        o_batch.res[3].final_res = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_cleave <= RST_N_CLEAVE;
            r_n_except <= RST_N_EXCEPT;
            r_c_cleave <= RST_C_CLEAVE;
            r_c_except <= RST_C_EXCEPT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_N_CLEAVE: r_n_cleave <= i_cfg_data;
                CFG_N_EXCEPT: r_n_except <= i_cfg_data;
                CFG_C_CLEAVE: r_c_cleave <= i_cfg_data;
                CFG_C_EXCEPT: r_c_except <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_prev      <= '0;
            r_pending   <= 1'b0;
            r_last_site <= '0;
            r_have_site <= 1'b0;
            r_count     <= '0;
            r_finished  <= 1'b0;
        end else if (i_fire) begin
            case (t_action'(i_action))
                ACT_FINISH: r_finished <= 1'b1;
                ACT_CLEAR: begin
                    r_position  <= '0;
                    r_prev      <= '0;
                    r_pending   <= 1'b0;
                    r_last_site <= '0;
                    r_have_site <= 1'b0;
                    r_count     <= '0;
                    r_finished  <= 1'b0;
                end
                ACT_RESIDUE: begin
                    if (!r_finished) begin
                        r_position  <= pos_inc;
                        r_prev      <= i_residue;
                        r_pending   <= letter_in(r_c_cleave, i_residue) && !i_last;
                        r_last_site <= n_last_site;
                        r_have_site <= r_have_site || (n_sites != 2'd0);
                        r_count     <= n_count;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pcss_queue.sv =====
`timescale 1ns / 1ps

module pcss_queue import pcss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_batch  i_batch,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result           r_mem [QDEPTH];
    logic [QPTR-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPTR:0]     r_count;
    logic [QPTR-1:0]   n_wr_ptr, n_rd_ptr;
    logic [QPTR:0]     n_count;

    logic [QPTR-1:0]   offset [NSLOT];
    logic [QPTR:0]     push_n;
    logic              pop;

    // compact the enabled slots onto consecutive entries
    always_comb begin
        push_n = '0;
        for (int k = 0; k < NSLOT; k++) begin
            offset[k] = push_n[QPTR-1:0];
            push_n    = push_n + (QPTR+1)'(i_batch.en[k]);
        end
    end

    assign pop      = o_valid && !i_stall;
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign o_space  = (r_count <= (QPTR+1)'(QDEPTH - NSLOT));

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_n[QPTR-1:0];
        n_rd_ptr = r_rd_ptr + QPTR'(pop);
        n_count  = r_count + push_n - (QPTR+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSLOT; k++) begin
            if (i_batch.en[k]) begin
                r_mem[r_wr_ptr + offset[k]] <= i_batch.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/protease_cleave_site_scanner.sv =====
`timescale 1ns / 1ps
// An item is registered on transfer; once the output queue has space its results are
// written into that queue, and the first result is offered from the queue head.
// Throughput: one item per cycle while the 8-entry output queue has four free entries;
// results leave one per cycle unless stalled; input stalls only when results back up.
// Reset (synchronous, active low) empties the queue, clears scan state, restores masks.

module protease_cleave_site_scanner import pcss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [RES_BITS-1:0]  i_residue,
    input  logic                 i_first_in_protein,
    input  logic                 i_last_in_protein,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [VAL_BITS-1:0]  o_value,
    output logic                 o_final_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [MASK_BITS-1:0] i_cfg_data
);

    logic                r_in_valid;
    logic [1:0]          r_action;
    logic [RES_BITS-1:0] r_residue;
    logic                r_first;
    logic                r_last;

    logic    space;
    logic    fire;
    logic    accept;
    t_batch  batch;
    t_result head;

    assign fire        = r_in_valid && space;
    assign o_stall     = r_in_valid && !space;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_residue <= i_residue;
            r_first   <= i_first_in_protein;
            r_last    <= i_last_in_protein;
        end
    end

    pcss_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_action    (r_action),
        .i_residue   (r_residue),
        .i_first     (r_first),
        .i_last      (r_last),
        .o_batch     (batch)
    );

    pcss_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_batch  (batch),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    assign o_kind      = head.kind;
    assign o_value     = head.value;
    assign o_final_res = head.final_res;

endmodule

// ===== rtl/pcss_checker.sv =====
`timescale 1ns / 1ps

module pcss_checker import pcss_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_kind,
    input logic [VAL_BITS-1:0] o_value,
    input logic                o_final_res
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_kind) && $stable(o_value) && $stable(o_final_res))
        else $error("stalled result changed");

    // a protein-end count always closes its item's results
    a_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_END) |-> o_final_res)
        else $error("protein end not marked final");

    // reset empties the queue and the input register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

bind protease_cleave_site_scanner pcss_checker u_pcss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_kind      (o_kind),
    .o_value     (o_value),
    .o_final_res (o_final_res)
);
